// File: hdl/text_console_writer_unit_defines.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, character codes and default screen geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int WORD_W = CHAR_W + ATTR_W;

  // Request codes carried in req_type.
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'h07;
  localparam logic [WORD_W-1:0] BLANK_CELL   = {COLOR_RESET, SPACE_CODE};

endpackage

// File: hdl/tcw_if.sv
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready channels for request words, result words and color writes.
// ----------------------------------------------------------------------------
interface tcw_in_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [WORD_W-1:0] cell_word;
  logic              scrolled;

  modport source (output valid, cursor_position, cell_word, scrolled, input ready);
  modport sink   (input valid, cursor_position, cell_word, scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_color;

  modport source (output valid, text_color, input ready);
  modport sink   (input valid, text_color, output ready);
endinterface

// File: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// Text console writer RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// Text console writer unit
// Character screen with cursor, line wrap and scroll, held in one cell RAM.
// ----------------------------------------------------------------------------
// The screen is ROWS x COLUMNS cells of 16 bits (attribute in the high byte,
// character in the low byte) kept in a single RAM with a registered read.
// After reset the block sweeps the RAM to blank light-grey cells, one cell a
// cycle; no request word is taken during that pass, but color writes are. A
// put word without a scroll and a read word each pass through S_IDLE and
// S_DONE: the word is taken in S_IDLE and its result is loaded into the
// output register in S_DONE once that register is free, so a new request is
// taken only after the last result is loaded. A put that runs past the last
// row scrolls the screen through the RAM's single write port: every row but
// the top one is copied up one row, one cell a cycle, and the bottom row is
// then blanked in the current color. The output register holds a finished
// result while the next request is already taken and worked on.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);

  localparam logic [AW-1:0] CELL_LAST = AW'(CELL_COUNT - 1);
  // Number of cells moved by a scroll, which is also the first bottom-row cell.
  localparam logic [AW-1:0] COPY_END  = AW'(CELL_COUNT - COLUMNS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COPY,
    S_BLANK,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt;
  logic [ATTR_W-1:0] color_r, color_nxt;
  logic              is_read_r, is_read_nxt;
  logic              in_range_r, in_range_nxt;
  logic              scr_r, scr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic [AW-1:0]     cur_addr;
  logic [POS_W-1:0]  cur_pos;

  tcw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Requests are taken only while the sequencer is idle; color writes always.
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // The output register may be reloaded once its word is gone or leaving.
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == S_DONE) && out_free;

  assign cur_addr = AW'(int'(cur_row_r) * COLUMNS + int'(cur_col_r));
  assign cur_pos  = POS_W'(int'(cur_row_r) * COLUMNS + int'(cur_col_r));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    color_nxt     = color_r;
    is_read_nxt   = is_read_r;
    in_range_nxt  = in_range_r;
    scr_nxt       = scr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_word_nxt  = out_word_r;
    out_scr_nxt   = out_scr_r;

    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = {color_r, SPACE_CODE};
    ram_re    = 1'b0;
    ram_raddr = AW'(in_ch.cell_index);

    if (cfg_ch.valid) begin
      color_nxt = cfg_ch.text_color;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_CELL;
        if (cnt_r == CELL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          is_read_nxt  = (in_ch.req_type == REQ_READ);
          in_range_nxt = 1'b0;
          scr_nxt      = 1'b0;
          state_nxt    = S_DONE;
          if (in_ch.req_type == REQ_READ) begin
            // Cells outside the screen read as zero and never touch the RAM.
            in_range_nxt = (int'(in_ch.cell_index) < CELL_COUNT);
            ram_re       = in_range_nxt;
          end else begin
            if (in_ch.char_code != NEWLINE_CODE) begin
              ram_we    = 1'b1;
              ram_waddr = cur_addr;
              ram_wdata = {color_r, in_ch.char_code};
            end
            if (in_ch.char_code == NEWLINE_CODE || cur_col_r == COL_LAST) begin
              cur_col_nxt = '0;
              if (cur_row_r == ROW_LAST) begin
                // Past the last row: the cursor stays there and the screen moves.
                scr_nxt   = 1'b1;
                cnt_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_COPY;
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end else begin
              cur_col_nxt = cur_col_r + 1'b1;
            end
          end
        end
      end

      S_COPY: begin
        // Reads run one cell ahead of writes: cell k+COLUMNS is read while the
        // cell read in the cycle before is written one row higher.
        pend_nxt      = (cnt_r != COPY_END);
        pend_addr_nxt = cnt_r;
        if (cnt_r != COPY_END) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r + AW'(COLUMNS);
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          state_nxt = S_BLANK;
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r;
          ram_wdata = ram_rdata;
        end
      end

      S_BLANK: begin
        ram_we = 1'b1;
        if (cnt_r == CELL_LAST) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = cur_pos;
          out_word_nxt  = (is_read_r && in_range_r) ? ram_rdata : '0;
          out_scr_nxt   = scr_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      pend_addr_r <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      color_r     <= COLOR_RESET;
      is_read_r   <= 1'b0;
      in_range_r  <= 1'b0;
      scr_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_pos_r   <= '0;
      out_word_r  <= '0;
      out_scr_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      pend_addr_r <= pend_addr_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      color_r     <= color_nxt;
      is_read_r   <= is_read_nxt;
      in_range_r  <= in_range_nxt;
      scr_r       <= scr_nxt;
      out_valid_r <= out_valid_nxt;
      out_pos_r   <= out_pos_nxt;
      out_word_r  <= out_word_nxt;
      out_scr_r   <= out_scr_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.cell_word       = out_word_r;
  assign out_ch.scrolled        = out_scr_r;

  // The cursor never leaves the screen.
  `TCW_ASSERT_NOW(a_cursor_on_screen, 1'b1, (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS), "cursor off screen")
  // Every write lands inside the screen.
  `TCW_ASSERT_NOW(a_write_in_range, ram_we, int'(ram_waddr) < CELL_COUNT, "RAM write out of range")
  // During the row copy the read pointer stays ahead of the write pointer.
  `TCW_ASSERT_NOW(a_copy_order, ram_we && ram_re, ram_raddr > ram_waddr, "copy overtakes its source")
  // A scrolled result always leaves the cursor at the start of the last row.
  `TCW_ASSERT_NOW(a_scroll_cursor, out_load && scr_r, (cur_row_r == ROW_LAST) && (cur_col_r == '0), "scroll left cursor astray")
  // A taken request keeps the input side closed until its result is loaded.
  `TCW_ASSERT_NEXT(a_one_in_flight, in_fire, !in_ch.ready, "second request taken too early")

endmodule
